FILE: rtl/core/gfba_pkg.sv
// Shared types, codes and constants of the grouped free block allocator.
`default_nettype none

package gfba_pkg;

    // Default sizing: slots per group and blocks on the device
    localparam int GROUP_DEF  = 16;
    localparam int BLOCKS_DEF = 256;

    // Fixed field widths of the item interfaces
    localparam int OP_W      = 2;
    localparam int BLK_NUM_W = 8;
    localparam int COUNT_W   = 9;

    // Operation codes
    localparam logic [OP_W-1:0] OP_FORMAT   = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd2;

    // Reset value of the reserved low block count
    localparam logic [BLK_NUM_W-1:0] RESERVED_RST = 8'd1;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [BLK_NUM_W-1:0] block_number;
    } gfba_in_t;

    typedef struct packed {
        logic [BLK_NUM_W-1:0] granted_block;
        logic                 status;
        logic [COUNT_W-1:0]   free_count;
    } gfba_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FMT_GROUP,
        ST_FMT_TOP,
        ST_ALLOC_CHK,
        ST_RELOAD_RD,
        ST_RELOAD_WR,
        ST_SPILL_RD,
        ST_SPILL_WR,
        ST_FINISH
    } gfba_state_t;

    // Datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_FMT_INIT,
        CMD_FMT_WORD,
        CMD_FMT_LINK,
        CMD_FMT_TOP,
        CMD_EMPTY,
        CMD_TOP_RD,
        CMD_EXHAUST,
        CMD_RELOAD_START,
        CMD_POP,
        CMD_RELOAD_RD,
        CMD_RELOAD_WR,
        CMD_PUSH,
        CMD_SPILL_RD,
        CMD_SPILL_WR,
        CMD_PUBLISH
    } gfba_cmd_t;

    // Datapath conditions seen by the controller
    typedef struct packed {
        logic op_format;
        logic op_allocate;
        logic op_release;
        logic fill_zero;
        logic fill_one;
        logic fill_full;
        logic blk_ok;
        logic group_left;
        logic top_left;
        logic idx_last;
        logic link_end;
        logic out_free;
    } gfba_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/grouped_free_block_allocator_core.sv
// Top level of the grouped free block allocator: controller and datapath.
// Push, pop, empty and unused codes give their result without moving a group.
// Group reload and group spill move each slot through a memory port, one read and one write per slot.
// Format writes one stored or top slot per cycle.
// Throughput: one item at a time, the next accepted the cycle after the result is registered.
// Reset clears fill, free count, reserved count (to 1) and control; memories are not cleared.
`default_nettype none

module grouped_free_block_allocator_core #(
    parameter int GROUP  = gfba_pkg::GROUP_DEF,
    parameter int BLOCKS = gfba_pkg::BLOCKS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire gfba_pkg::gfba_in_t             in_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output gfba_pkg::gfba_out_t                 out_item,
    input  wire logic                           cfg_we,
    input  wire logic [gfba_pkg::BLK_NUM_W-1:0] cfg_wdata
);

    gfba_pkg::gfba_cmd_t  cmd;
    gfba_pkg::gfba_stat_t stat;

    // Sequence each item
    gfba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the free list and the result
    gfba_datapath #(
        .GROUP  (GROUP),
        .BLOCKS (BLOCKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

FILE: rtl/core/gfba_ctrl.sv
// Controller state machine of the grouped free block allocator.
`default_nettype none

module gfba_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire gfba_pkg::gfba_stat_t stat,
    output gfba_pkg::gfba_cmd_t       cmd
);

    gfba_pkg::gfba_state_t state_reg;
    gfba_pkg::gfba_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gfba_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance to the next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gfba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gfba_pkg::ST_DISPATCH;
                end
            end
            gfba_pkg::ST_DISPATCH:
            begin
                if (stat.op_format)
                begin
                    state_next = gfba_pkg::ST_FMT_GROUP;
                end
                else if (stat.op_allocate && !stat.fill_zero)
                begin
                    state_next = gfba_pkg::ST_ALLOC_CHK;
                end
                else if (stat.op_release && stat.blk_ok && stat.fill_full)
                begin
                    state_next = gfba_pkg::ST_SPILL_RD;
                end
                else
                begin
                    state_next = gfba_pkg::ST_FINISH;
                end
            end
            gfba_pkg::ST_FMT_GROUP:
            begin
                if (!stat.group_left)
                begin
                    state_next = gfba_pkg::ST_FMT_TOP;
                end
            end
            gfba_pkg::ST_FMT_TOP:
            begin
                if (!stat.top_left)
                begin
                    state_next = gfba_pkg::ST_FINISH;
                end
            end
            gfba_pkg::ST_ALLOC_CHK:
            begin
                if (stat.fill_one && !stat.link_end)
                begin
                    state_next = gfba_pkg::ST_RELOAD_RD;
                end
                else
                begin
                    state_next = gfba_pkg::ST_FINISH;
                end
            end
            gfba_pkg::ST_RELOAD_RD:
            begin
                state_next = gfba_pkg::ST_RELOAD_WR;
            end
            gfba_pkg::ST_RELOAD_WR:
            begin
                state_next = stat.idx_last ? gfba_pkg::ST_FINISH : gfba_pkg::ST_RELOAD_RD;
            end
            gfba_pkg::ST_SPILL_RD:
            begin
                state_next = gfba_pkg::ST_SPILL_WR;
            end
            gfba_pkg::ST_SPILL_WR:
            begin
                state_next = stat.idx_last ? gfba_pkg::ST_FINISH : gfba_pkg::ST_SPILL_RD;
            end
            gfba_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = gfba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gfba_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive the datapath commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = gfba_pkg::CMD_NONE;
        unique case (state_reg)
            gfba_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = gfba_pkg::CMD_LOAD;
                end
            end
            gfba_pkg::ST_DISPATCH:
            begin
                if (stat.op_format)
                begin
                    cmd = gfba_pkg::CMD_FMT_INIT;
                end
                else if (stat.op_allocate)
                begin
                    cmd = stat.fill_zero ? gfba_pkg::CMD_EMPTY : gfba_pkg::CMD_TOP_RD;
                end
                else if (stat.op_release && stat.blk_ok && !stat.fill_full)
                begin
                    cmd = gfba_pkg::CMD_PUSH;
                end
            end
            gfba_pkg::ST_FMT_GROUP:
            begin
                cmd = stat.group_left ? gfba_pkg::CMD_FMT_WORD : gfba_pkg::CMD_FMT_LINK;
            end
            gfba_pkg::ST_FMT_TOP:
            begin
                if (stat.top_left)
                begin
                    cmd = gfba_pkg::CMD_FMT_TOP;
                end
            end
            gfba_pkg::ST_ALLOC_CHK:
            begin
                if (!stat.fill_one)
                begin
                    cmd = gfba_pkg::CMD_POP;
                end
                else
                begin
                    cmd = stat.link_end ? gfba_pkg::CMD_EXHAUST : gfba_pkg::CMD_RELOAD_START;
                end
            end
            gfba_pkg::ST_RELOAD_RD:
            begin
                cmd = gfba_pkg::CMD_RELOAD_RD;
            end
            gfba_pkg::ST_RELOAD_WR:
            begin
                cmd = gfba_pkg::CMD_RELOAD_WR;
            end
            gfba_pkg::ST_SPILL_RD:
            begin
                cmd = gfba_pkg::CMD_SPILL_RD;
            end
            gfba_pkg::ST_SPILL_WR:
            begin
                cmd = gfba_pkg::CMD_SPILL_WR;
            end
            gfba_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd = gfba_pkg::CMD_PUBLISH;
                end
            end
            default:
            begin
                cmd = gfba_pkg::CMD_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/gfba_datapath.sv
// Datapath of the grouped free block allocator: counters, group memories, result register.
`default_nettype none

module gfba_datapath #(
    parameter int GROUP  = gfba_pkg::GROUP_DEF,
    parameter int BLOCKS = gfba_pkg::BLOCKS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire gfba_pkg::gfba_cmd_t                 cmd,
    output gfba_pkg::gfba_stat_t                     stat,
    input  wire gfba_pkg::gfba_in_t                  in_item,
    input  wire logic                                cfg_we,
    input  wire logic [gfba_pkg::BLK_NUM_W-1:0]      cfg_wdata,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output gfba_pkg::gfba_out_t                      out_item
);

    localparam int          SLOT_W   = $clog2(BLOCKS + 1);
    localparam int          BLK_W    = $clog2(BLOCKS);
    localparam int          IDX_W    = $clog2(GROUP);
    localparam int          FILL_W   = $clog2(GROUP + 1);
    localparam int          ST_DEPTH = BLOCKS << IDX_W;
    localparam int          ST_AW    = BLK_W + IDX_W;
    localparam logic [31:0] BLOCKS_U = 32'(BLOCKS);
    localparam logic [31:0] GROUP_U  = 32'(GROUP);

    localparam int BN_W = gfba_pkg::BLK_NUM_W;
    localparam int CN_W = gfba_pkg::COUNT_W;

    // Control state
    logic [BN_W-1:0]   reserved_reg, reserved_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CN_W-1:0]   total_reg, total_next;
    logic              out_valid_reg, out_valid_next;

    // Working registers of one item
    logic [gfba_pkg::OP_W-1:0] op_reg, op_next;
    logic [BN_W-1:0]           blk_reg, blk_next;
    logic [SLOT_W-1:0]         cursor_reg, cursor_next;
    logic [SLOT_W-1:0]         link_reg, link_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [BN_W-1:0]           granted_reg, granted_next;
    logic                      status_reg, status_next;
    gfba_pkg::gfba_out_t       out_item_reg, out_item_next;

    // Memories
    logic [SLOT_W-1:0] top_mem [GROUP];
    logic [SLOT_W-1:0] st_mem  [ST_DEPTH];
    logic [SLOT_W-1:0] top_rdata_reg;
    logic [SLOT_W-1:0] st_rdata_reg;

    logic              top_we;
    logic              top_re;
    logic [IDX_W-1:0]  top_waddr;
    logic [IDX_W-1:0]  top_raddr;
    logic [SLOT_W-1:0] top_wdata;
    logic              st_we;
    logic              st_re;
    logic [ST_AW-1:0]  st_addr;
    logic [SLOT_W-1:0] st_wdata;

    logic [SLOT_W-1:0] cursor_init;
    logic [31:0]       blk_wide;
    logic [31:0]       link_wide;
    logic [31:0]       cursor_wide;
    logic              idx_last;

    assign blk_wide    = 32'(blk_reg);
    assign link_wide   = 32'(link_reg);
    assign cursor_wide = 32'(cursor_reg);
    assign idx_last    = (idx_reg == IDX_W'(GROUP - 1));
    assign cursor_init = (32'(reserved_reg) > BLOCKS_U) ? SLOT_W'(BLOCKS) : SLOT_W'(reserved_reg);

    // Report conditions to the controller
    always_comb
    begin
        stat.op_format   = (op_reg == gfba_pkg::OP_FORMAT);
        stat.op_allocate = (op_reg == gfba_pkg::OP_ALLOCATE);
        stat.op_release  = (op_reg == gfba_pkg::OP_RELEASE);
        stat.fill_zero   = (fill_reg == '0);
        stat.fill_one    = (fill_reg == FILL_W'(1));
        stat.fill_full   = (32'(fill_reg) >= GROUP_U);
        stat.blk_ok      = (blk_wide < BLOCKS_U);
        stat.group_left  = ((BLOCKS_U - cursor_wide) >= GROUP_U);
        stat.top_left    = (cursor_wide < BLOCKS_U);
        stat.idx_last    = idx_last;
        stat.link_end    = (32'(top_rdata_reg) >= BLOCKS_U);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // Decode the command into register updates and memory accesses
    always_comb
    begin
        reserved_next  = cfg_we ? cfg_wdata : reserved_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        op_next        = op_reg;
        blk_next       = blk_reg;
        cursor_next    = cursor_reg;
        link_next      = link_reg;
        idx_next       = idx_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        top_we    = 1'b0;
        top_re    = 1'b0;
        top_waddr = '0;
        top_raddr = '0;
        top_wdata = '0;
        st_we     = 1'b0;
        st_re     = 1'b0;
        st_addr   = {link_reg[BLK_W-1:0], idx_reg};
        st_wdata  = '0;

        unique case (cmd)
            gfba_pkg::CMD_NONE:
            begin
            end
            gfba_pkg::CMD_LOAD:
            begin
                op_next      = in_item.operation;
                blk_next     = in_item.block_number;
                idx_next     = '0;
                granted_next = '0;
                status_next  = 1'b0;
            end
            gfba_pkg::CMD_FMT_INIT:
            begin
                cursor_next = cursor_init;
                total_next  = CN_W'(BLOCKS_U - 32'(cursor_init));
                link_next   = SLOT_W'(BLOCKS);
            end
            gfba_pkg::CMD_FMT_WORD:
            begin
                // Build one stored group in the holder block at the cursor
                st_we    = 1'b1;
                st_addr  = {cursor_reg[BLK_W-1:0], idx_reg};
                st_wdata = (idx_reg == '0) ? link_reg : (cursor_reg + SLOT_W'(idx_reg));
                if (idx_last)
                begin
                    link_next   = cursor_reg;
                    cursor_next = SLOT_W'(cursor_wide + GROUP_U);
                    idx_next    = '0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            gfba_pkg::CMD_FMT_LINK:
            begin
                top_we    = 1'b1;
                top_waddr = '0;
                top_wdata = link_reg;
                fill_next = FILL_W'(1);
            end
            gfba_pkg::CMD_FMT_TOP:
            begin
                top_we      = 1'b1;
                top_waddr   = IDX_W'(fill_reg);
                top_wdata   = cursor_reg;
                fill_next   = fill_reg + FILL_W'(1);
                cursor_next = cursor_reg + SLOT_W'(1);
            end
            gfba_pkg::CMD_EMPTY:
            begin
                status_next = 1'b1;
            end
            gfba_pkg::CMD_TOP_RD:
            begin
                top_re    = 1'b1;
                top_raddr = IDX_W'(fill_reg - FILL_W'(1));
            end
            gfba_pkg::CMD_EXHAUST:
            begin
                fill_next   = '0;
                status_next = 1'b1;
            end
            gfba_pkg::CMD_RELOAD_START:
            begin
                // Hand out the link block and reload its group
                link_next    = top_rdata_reg;
                granted_next = BN_W'(top_rdata_reg);
                total_next   = total_reg - CN_W'(1);
            end
            gfba_pkg::CMD_POP:
            begin
                fill_next    = fill_reg - FILL_W'(1);
                granted_next = BN_W'(top_rdata_reg);
                total_next   = total_reg - CN_W'(1);
            end
            gfba_pkg::CMD_RELOAD_RD:
            begin
                st_re   = 1'b1;
                st_addr = {link_reg[BLK_W-1:0], idx_reg};
            end
            gfba_pkg::CMD_RELOAD_WR:
            begin
                top_we    = 1'b1;
                top_waddr = idx_reg;
                top_wdata = st_rdata_reg;
                if (idx_last)
                begin
                    fill_next = FILL_W'(GROUP);
                    idx_next  = '0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            gfba_pkg::CMD_PUSH:
            begin
                top_we     = 1'b1;
                top_waddr  = IDX_W'(fill_reg);
                top_wdata  = SLOT_W'(blk_wide);
                fill_next  = fill_reg + FILL_W'(1);
                total_next = total_reg + CN_W'(1);
            end
            gfba_pkg::CMD_SPILL_RD:
            begin
                top_re    = 1'b1;
                top_raddr = idx_reg;
            end
            gfba_pkg::CMD_SPILL_WR:
            begin
                // Copy the full top group into the released block
                st_we    = 1'b1;
                st_addr  = {blk_wide[BLK_W-1:0], idx_reg};
                st_wdata = top_rdata_reg;
                if (idx_last)
                begin
                    top_we     = 1'b1;
                    top_waddr  = '0;
                    top_wdata  = SLOT_W'(blk_wide);
                    fill_next  = FILL_W'(1);
                    total_next = total_reg + CN_W'(1);
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            gfba_pkg::CMD_PUBLISH:
            begin
                out_valid_next               = 1'b1;
                out_item_next.granted_block  = granted_reg;
                out_item_next.status         = status_reg;
                out_item_next.free_count     = total_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg  <= gfba_pkg::RESERVED_RST;
            fill_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            reserved_reg  <= reserved_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        blk_reg      <= blk_next;
        cursor_reg   <= cursor_next;
        link_reg     <= link_next;
        idx_reg      <= idx_next;
        granted_reg  <= granted_next;
        status_reg   <= status_next;
        out_item_reg <= out_item_next;
    end

    // Top group memory
    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[top_waddr] <= top_wdata;
        end
        if (top_re)
        begin
            top_rdata_reg <= top_mem[top_raddr];
        end
    end

    // Stored group memory, one port
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_addr] <= st_wdata;
        end
        if (st_re)
        begin
            st_rdata_reg <= st_mem[st_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= GROUP_U)
        else $error("top group fill beyond group size");

    a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == gfba_pkg::CMD_POP |=> fill_reg == $past(fill_reg) - FILL_W'(1))
        else $error("pop did not drop the fill by one");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == gfba_pkg::CMD_PUSH |=> total_reg == $past(total_reg) + CN_W'(1))
        else $error("push did not raise the free count by one");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == gfba_pkg::CMD_PUBLISH |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while still waiting");

    a_reload_link: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == gfba_pkg::CMD_RELOAD_RD |-> link_wide < BLOCKS_U)
        else $error("reload through the end link");
`endif

endmodule

`default_nettype wire
